/* src/lzsd_pkg.sv */
// Shared types and constants of the LZ stream decompressor.
// No dependencies; used by lz_stream_decompressor and lzsd_checker.
package lzsd_pkg;

    typedef enum logic [6:0] {
        PH_HEADER  = 7'b0000001,
        PH_TOKEN   = 7'b0000010,
        PH_LITERAL = 7'b0000100,
        PH_COPY    = 7'b0001000,
        PH_TRAILER = 7'b0010000,
        PH_DONE    = 7'b0100000,
        PH_ERROR   = 7'b1000000
    } phase_t;

    typedef enum logic [3:0] {
        ST_OK         = 4'd0,
        ST_BAD_MAGIC  = 4'd1,
        ST_TOO_LARGE  = 4'd2,
        ST_OVERFLOW   = 4'd3,
        ST_BAD_DIST   = 4'd4,
        ST_BAD_TOKEN  = 4'd5,
        ST_LEN_MISMT  = 4'd6,
        ST_SUM_MISMT  = 4'd7,
        ST_BUSY       = 4'd8
    } status_t;

    localparam logic [31:0] MAGIC_WORD  = 32'h57BC_0000;
    localparam logic [16:0] SUM_MODULUS = 17'd65521;
    localparam logic [7:0]  TRAILER_B1  = 8'hFA;

    localparam logic REQ_BYTE = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    // result word layout
    typedef struct packed {
        logic [3:0] status;
        logic       done_res;
        logic       copy_pending;
        logic [7:0] out_byte;
        logic       out_valid;
    } res_t;

    function automatic logic [2:0] token_len(input logic [7:0] b);
        logic [2:0] len;
        begin
            if (b >= 8'h80)      len = 3'd2;
            else if (b >= 8'h40) len = 3'd3;
            else if (b >= 8'h20) len = 3'd1;
            else if (b >= 8'h18) len = 3'd4;
            else if (b >= 8'h10) len = 3'd5;
            else if (b >= 8'h08) len = 3'd2;
            else if (b == 8'h07) len = 3'd3;
            else if (b == 8'h06) len = 3'd5;
            else if (b == 8'h05) len = 3'd2;
            else if (b == 8'h04) len = 3'd6;
            else                 len = 3'd0;
            token_len = len;
        end
    endfunction

endpackage

/* src/lz_stream_decompressor.sv */
// LZ stream decompressor: header/token decode, history memory, Adler-32 check.
// Depends on lzsd_pkg.
//
//  channel | dir | tdata                 | tuser
//  s_      | in  | in_byte[7:0]          | req_type (0 byte, 1 tick)
//  m_      | out | res_t, 15 bits in 16  | -
//
// One word accepted per cycle unless m_ stalls; results pass the memory stage to m_.
// Rate is set by the history memory: one read and one write port per cycle,
// with the previous byte forwarded when a match has distance one.
// Reset clears the control state only; the history needs no clearing pass.
// A stall on m_ holds the result and the word behind it, then s_tready drops.
module lz_stream_decompressor
    import lzsd_pkg::*;
#(
    parameter int HIST_DEPTH = 65536
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic        s_tuser,   // [0] req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [0] out_valid, [8:1] out_byte, [9] copy_pending,
                                   // [10] done_res, [14:11] status, [15] zero
);

    localparam int AW = $clog2(HIST_DEPTH);

    // decode stage state
    phase_t       phase_reg, phase_next;
    logic [3:0]   bcnt_reg, bcnt_next;
    logic [39:0]  tok_reg, tok_next;
    logic [7:0]   tfirst_reg, tfirst_next;
    logic [2:0]   tlen_reg, tlen_next;
    logic [16:0]  lit_left_reg, lit_left_next;
    logic [16:0]  copy_left_reg, copy_left_next;
    logic [23:0]  copy_dist_reg, copy_dist_next;
    logic [31:0]  out_cnt_reg, out_cnt_next;
    logic [31:0]  exp_len_reg, exp_len_next;
    logic [31:0]  trl_reg, trl_next;
    logic [3:0]   err_reg, err_next;
    logic [AW-1:0] wptr_reg, wptr_next;

    // memory/result stage
    logic          p_valid_reg;
    logic          p_emit_reg, p_copy_reg, p_fwd_reg;
    logic [7:0]    p_lit_reg;
    logic          p_pend_reg, p_done_reg;
    logic [3:0]    p_stat_reg;
    logic [AW-1:0] p_waddr_reg;

    logic [15:0]  sum_lo_reg, sum_hi_reg;
    logic [7:0]   last_byte_reg;
    logic         m_valid_reg;
    res_t         m_res_reg;

    logic [7:0]   hist_mem [HIST_DEPTH];
    logic [7:0]   rd_q;

    logic         s_acc, out_free, p_adv;
    logic         e_emit, e_copy;
    logic [AW-1:0] rd_addr;
    logic [AW:0]  sub;
    logic [7:0]   b, b0;
    logic [47:0]  v;
    logic [2:0]   len_now;
    logic         f_lit, f_trl, f_badtok;
    logic [16:0]  f_run;
    logic [24:0]  f_dist;
    logic         f_ovf, f_baddist;
    logic         finish;
    logic [7:0]   p_byte;
    logic [16:0]  lo_sum, hi_sum;
    logic [15:0]  lo_new, hi_new;

    assign out_free = !m_valid_reg || m_tready;
    assign p_adv    = p_valid_reg && out_free;
    assign s_tready = !p_valid_reg || out_free;
    assign s_acc    = s_tvalid && s_tready;
    assign b        = s_tdata;
    assign b0       = (bcnt_reg == 4'd0) ? b : tfirst_reg;
    assign v        = {tok_reg, b};

    // source address of a match byte, modulo the history depth
    assign sub = {1'b0, wptr_reg} - ({1'b0, copy_dist_reg[AW-1:0]} + (AW+1)'(1));
    assign rd_addr = sub[AW] ? (sub[AW-1:0] + AW'(HIST_DEPTH)) : sub[AW-1:0];

    // token field decode
    always_comb begin
        f_lit = 1'b0;
        f_trl = 1'b0;
        f_badtok = 1'b0;
        f_run = '0;
        f_dist = '0;
        if (b0 >= 8'h80) begin
            f_run  = 17'({1'b0, b0[6:0]}) + 17'd1;
            f_dist = 25'(v[7:0]) + 25'd1;
        end else if (b0 >= 8'h40) begin
            f_dist = 25'({b0[5:0], v[15:8]}) + 25'd1;
            f_run  = 17'(v[7:0]) + 17'd1;
        end else if (b0 >= 8'h20) begin
            f_lit = 1'b1;
            f_run = 17'(b0[4:0]) + 17'd1;
        end else if (b0 >= 8'h18) begin
            f_dist = 25'({b0[2:0], v[23:8]}) + 25'd1;
            f_run  = 17'(v[7:0]) + 17'd1;
        end else if (b0 >= 8'h10) begin
            f_dist = 25'({b0[2:0], v[31:16]}) + 25'd1;
            f_run  = 17'(v[15:0]) + 17'd1;
        end else if (b0 >= 8'h08) begin
            f_lit = 1'b1;
            f_run = 17'({b0[2:0], v[7:0]}) + 17'd1;
        end else if (b0 == 8'h07) begin
            f_lit = 1'b1;
            f_run = 17'(v[15:0]) + 17'd1;
        end else if (b0 == 8'h06) begin
            f_dist = 25'(v[31:8]) + 25'd1;
            f_run  = 17'(v[7:0]) + 17'd1;
        end else if (b0 == 8'h04) begin
            f_dist = 25'(v[39:16]) + 25'd1;
            f_run  = 17'(v[15:0]) + 17'd1;
        end else begin
            f_trl = 1'b1;
            f_badtok = (v[7:0] != TRAILER_B1);
        end
    end

    assign f_ovf = ({1'b0, out_cnt_reg} + 33'(f_run)) > {1'b0, exp_len_reg};
    assign f_baddist = (33'(f_dist) > {1'b0, out_cnt_reg})
                    || (f_dist > 25'(HIST_DEPTH));
    assign len_now = (bcnt_reg == 4'd0) ? token_len(b) : tlen_reg;

    // decode stage next state
    always_comb begin
        phase_next     = phase_reg;
        bcnt_next      = bcnt_reg;
        tok_next       = tok_reg;
        tfirst_next    = tfirst_reg;
        tlen_next      = tlen_reg;
        lit_left_next  = lit_left_reg;
        copy_left_next = copy_left_reg;
        copy_dist_next = copy_dist_reg;
        out_cnt_next   = out_cnt_reg;
        exp_len_next   = exp_len_reg;
        trl_next       = trl_reg;
        err_next       = err_reg;
        e_emit         = 1'b0;
        e_copy         = 1'b0;
        finish         = 1'b0;
        if (s_acc && s_tuser == REQ_TICK) begin
            if (phase_reg == PH_COPY) begin
                e_emit = 1'b1;
                e_copy = 1'b1;
                copy_left_next = copy_left_reg - 17'd1;
                if (copy_left_reg == 17'd1) phase_next = PH_TOKEN;
            end
        end else if (s_acc) begin
            case (phase_reg)
                PH_HEADER: begin
                    if (bcnt_reg < 4'd4) begin
                        if (b != MAGIC_WORD[8*(3-bcnt_reg[1:0]) +: 8]) begin
                            err_next = ST_BAD_MAGIC;
                            phase_next = PH_ERROR;
                        end
                    end else if (bcnt_reg < 4'd8) begin
                        if (b != 8'd0) begin
                            err_next = ST_TOO_LARGE;
                            phase_next = PH_ERROR;
                        end
                    end else if (bcnt_reg < 4'd12) begin
                        exp_len_next = {exp_len_reg[23:0], b};
                    end
                    if (phase_next != PH_ERROR) begin
                        if (bcnt_reg == 4'd15) begin
                            phase_next = PH_TOKEN;
                            bcnt_next = 4'd0;
                        end else begin
                            bcnt_next = bcnt_reg + 4'd1;
                        end
                    end
                end
                PH_TOKEN: begin
                    if (len_now == 3'd0) begin
                        err_next = ST_BAD_TOKEN;
                        phase_next = PH_ERROR;
                    end else if (bcnt_reg == 4'd0 && len_now == 3'd1) begin
                        finish = 1'b1;
                    end else if (bcnt_reg == 4'd0) begin
                        tok_next = 40'(b);
                        tfirst_next = b;
                        tlen_next = len_now;
                        bcnt_next = 4'd1;
                    end else if (bcnt_reg + 4'd1 >= 4'(len_now)) begin
                        bcnt_next = 4'd0;
                        tok_next = '0;
                        finish = 1'b1;
                    end else begin
                        tok_next = v[39:0];
                        bcnt_next = bcnt_reg + 4'd1;
                    end
                end
                PH_LITERAL: begin
                    e_emit = 1'b1;
                    lit_left_next = lit_left_reg - 17'd1;
                    if (lit_left_reg == 17'd1) phase_next = PH_TOKEN;
                end
                PH_COPY: begin
                    err_next = ST_BUSY;
                    phase_next = PH_ERROR;
                end
                PH_TRAILER: begin
                    trl_next = {trl_reg[23:0], b};
                    bcnt_next = bcnt_reg + 4'd1;
                    if (bcnt_reg == 4'd3) begin
                        bcnt_next = 4'd0;
                        if (out_cnt_reg != exp_len_reg) begin
                            err_next = ST_LEN_MISMT;
                            phase_next = PH_ERROR;
                        end else if ({sum_hi_reg, sum_lo_reg} != {trl_reg[23:0], b}) begin
                            err_next = ST_SUM_MISMT;
                            phase_next = PH_ERROR;
                        end else begin
                            phase_next = PH_DONE;
                        end
                    end
                end
                default: ;
            endcase
        end
        if (finish) begin
            if (f_trl) begin
                if (f_badtok) begin
                    err_next = ST_BAD_TOKEN;
                    phase_next = PH_ERROR;
                end else begin
                    phase_next = PH_TRAILER;
                    bcnt_next = 4'd0;
                    trl_next = '0;
                end
            end else if (f_ovf) begin
                err_next = ST_OVERFLOW;
                phase_next = PH_ERROR;
            end else if (f_lit) begin
                lit_left_next = f_run;
                phase_next = PH_LITERAL;
            end else if (f_baddist) begin
                err_next = ST_BAD_DIST;
                phase_next = PH_ERROR;
            end else begin
                copy_left_next = f_run;
                copy_dist_next = 24'(f_dist - 25'd1);
                phase_next = PH_COPY;
            end
        end
        if (e_emit) out_cnt_next = out_cnt_reg + 32'd1;
    end

    assign wptr_next = !e_emit ? wptr_reg
                     : (wptr_reg == AW'(HIST_DEPTH - 1)) ? '0 : wptr_reg + AW'(1);

    // byte of the item in the memory stage
    assign p_byte = !p_copy_reg ? p_lit_reg : (p_fwd_reg ? last_byte_reg : rd_q);

    assign lo_sum = 17'(sum_lo_reg) + 17'(p_byte);
    assign lo_new = (lo_sum >= SUM_MODULUS) ? 16'(lo_sum - SUM_MODULUS) : lo_sum[15:0];
    assign hi_sum = 17'(sum_hi_reg) + 17'(lo_new);
    assign hi_new = (hi_sum >= SUM_MODULUS) ? 16'(hi_sum - SUM_MODULUS) : hi_sum[15:0];

    always_ff @(posedge aclk) begin
        if (p_adv && p_emit_reg) hist_mem[p_waddr_reg] <= p_byte;
        if (s_acc && e_copy) rd_q <= hist_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_HEADER;
            bcnt_reg      <= '0;
            tok_reg       <= '0;
            tfirst_reg    <= '0;
            tlen_reg      <= '0;
            lit_left_reg  <= '0;
            copy_left_reg <= '0;
            copy_dist_reg <= '0;
            out_cnt_reg   <= '0;
            exp_len_reg   <= '0;
            trl_reg       <= '0;
            err_reg       <= ST_OK;
            wptr_reg      <= '0;
            p_valid_reg   <= 1'b0;
            sum_lo_reg    <= 16'd1;
            sum_hi_reg    <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            phase_reg     <= phase_next;
            bcnt_reg      <= bcnt_next;
            tok_reg       <= tok_next;
            tfirst_reg    <= tfirst_next;
            tlen_reg      <= tlen_next;
            lit_left_reg  <= lit_left_next;
            copy_left_reg <= copy_left_next;
            copy_dist_reg <= copy_dist_next;
            out_cnt_reg   <= out_cnt_next;
            exp_len_reg   <= exp_len_next;
            trl_reg       <= trl_next;
            err_reg       <= err_next;
            wptr_reg      <= wptr_next;
            if (s_acc) p_valid_reg <= 1'b1;
            else if (p_adv) p_valid_reg <= 1'b0;
            if (p_adv && p_emit_reg) begin
                sum_lo_reg <= lo_new;
                sum_hi_reg <= hi_new;
            end
            if (p_adv) m_valid_reg <= 1'b1;
            else if (m_tready) m_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_acc) begin
            p_emit_reg  <= e_emit;
            p_copy_reg  <= e_copy;
            // distance one reads the byte written at this same edge
            p_fwd_reg   <= (copy_dist_reg == 24'd0) && p_adv && p_emit_reg;
            p_lit_reg   <= b;
            p_pend_reg  <= (phase_next == PH_COPY);
            p_done_reg  <= (phase_next == PH_DONE);
            p_stat_reg  <= err_next;
            p_waddr_reg <= wptr_reg;
        end
        if (p_adv && p_emit_reg) last_byte_reg <= p_byte;
        if (p_adv) begin
            m_res_reg.out_valid    <= p_emit_reg;
            m_res_reg.out_byte     <= p_emit_reg ? p_byte : 8'd0;
            m_res_reg.copy_pending <= p_pend_reg;
            m_res_reg.done_res     <= p_done_reg;
            m_res_reg.status       <= p_stat_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, m_res_reg};

endmodule

/* src/lzsd_checker.sv */
// Port-level checks of the LZ stream decompressor, bound to the top level.
// Depends on lzsd_pkg and lz_stream_decompressor.
module lzsd_checker
    import lzsd_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    a_zero_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[0] |-> m_tdata[8:1] == 8'd0)
        else $error("byte set without out_valid");

    a_done_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[10] |-> m_tdata[14:11] == ST_OK && !m_tdata[9])
        else $error("done with error or pending copy");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !m_tdata[15])
        else $error("pad bit set");

endmodule

bind lz_stream_decompressor lzsd_checker u_lzsd_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
);

/* tb/lz_stream_decompressor_tb.sv */
// Self-checking testbench for lz_stream_decompressor: builds one compressed stream
// (directed tokens, random tokens, a randomly chosen ending), predicts every result.
// Depends on lzsd_pkg and the RTL only.
module lz_stream_decompressor_tb
    import lzsd_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HIST = 65536;
    localparam int STALL_LIMIT = 2000;

    typedef struct {
        logic       kind;
        logic [7:0] b;
    } word_t;

    typedef enum int {
        TK_LIT_SHORT, TK_LIT_MID, TK_LIT_LONG,
        TK_MATCH_S, TK_MATCH_M, TK_MATCH_L, TK_MATCH_LL, TK_MATCH_X, TK_MATCH_XL
    } tok_kind_t;

    typedef enum int {
        END_GOOD, END_SUM, END_LEN, END_BAD_TOKEN, END_BAD_FA, END_OVERFLOW,
        END_BAD_DIST, END_BUSY, END_MAGIC, END_UPPER
    } end_kind_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;

    lz_stream_decompressor dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    word_t      pending[$];
    res_t       expected_res[$];
    logic [7:0] gen_out[$];
    int         errors = 0;
    int         words_out = 0;
    bit         quiet = 0;

    // ---------------- decoder model ----------------
    phase_t      ph = PH_HEADER;
    logic [3:0]  cnt = '0;
    logic [39:0] tok = '0;
    logic [16:0] lit_left = '0;
    logic [16:0] cp_left = '0;
    logic [23:0] cp_dist = '0;
    logic [31:0] n_out = '0;
    logic [31:0] exp_len = '0;
    logic [15:0] sum_a = 16'd1;
    logic [15:0] sum_b = '0;
    logic [31:0] trl = '0;
    status_t     err = ST_OK;
    logic [7:0]  hist[0:HIST-1];
    logic        cur_valid;
    logic [7:0]  cur_byte;

    function automatic int tok_size(logic [7:0] b);
        if (b >= 8'h80) return 2;
        if (b >= 8'h40) return 3;
        if (b >= 8'h20) return 1;
        if (b >= 8'h18) return 4;
        if (b >= 8'h10) return 5;
        if (b >= 8'h08) return 2;
        case (b)
            8'h07: return 3;
            8'h06: return 5;
            8'h05: return 2;
            8'h04: return 6;
            default: return 0;
        endcase
    endfunction

    function void fault(status_t code);
        err = code;
        ph = PH_ERROR;
    endfunction

    function void put_out(logic [7:0] b);
        hist[n_out[15:0]] = b;
        n_out = n_out + 1;
        sum_a = 16'((32'(sum_a) + b) % 65521);
        sum_b = 16'((32'(sum_b) + sum_a) % 65521);
        cur_valid = 1'b1;
        cur_byte = b;
    endfunction

    function void close_token(logic [47:0] v, int len);
        logic [7:0]  b0;
        logic [7:0]  b1;
        logic [31:0] run;
        logic [31:0] back;
        bit          is_match;
        b0 = v[8*(len-1) +: 8];
        b1 = (len > 1) ? v[8*(len-2) +: 8] : 8'h00;
        is_match = 1;
        run = 0;
        back = 0;
        if (b0 >= 8'h80) begin
            run = 32'(b0) - 32'h80 + 1;
            back = 32'(b1) + 1;
        end else if (b0 >= 8'h40) begin
            back = 32'({b0, b1}) - 32'h4000 + 1;
            run = 32'(v[7:0]) + 1;
        end else if (b0 >= 8'h20) begin
            is_match = 0;
            run = 32'(b0) - 32'h20 + 1;
        end else if (b0 >= 8'h18) begin
            back = 32'(v[31:8]) - 32'h180000 + 1;
            run = 32'(v[7:0]) + 1;
        end else if (b0 >= 8'h10) begin
            back = 32'(v[39:16]) - 32'h100000 + 1;
            run = 32'(v[15:0]) + 1;
        end else if (b0 >= 8'h08) begin
            is_match = 0;
            run = 32'({b0, b1}) - 32'h0800 + 1;
        end else if (b0 == 8'h07) begin
            is_match = 0;
            run = 32'(v[15:0]) + 1;
        end else if (b0 == 8'h06) begin
            back = 32'(v[31:8]) + 1;
            run = 32'(v[7:0]) + 1;
        end else if (b0 == 8'h04) begin
            back = 32'(v[39:16]) + 1;
            run = 32'(v[15:0]) + 1;
        end else begin
            // 05 must be followed by FA to open the trailer
            if (b1 != TRAILER_B1) begin
                fault(ST_BAD_TOKEN);
                return;
            end
            ph = PH_TRAILER;
            cnt = 0;
            trl = 0;
            return;
        end
        if (33'(n_out) + 33'(run) > 33'(exp_len)) begin
            fault(ST_OVERFLOW);
            return;
        end
        if (is_match) begin
            if (back > n_out || back > HIST) begin
                fault(ST_BAD_DIST);
                return;
            end
            cp_left = 17'(run);
            cp_dist = 24'(back - 1);
            ph = PH_COPY;
        end else begin
            lit_left = 17'(run);
            ph = PH_LITERAL;
        end
    endfunction

    function void take_byte(logic [7:0] b);
        int          len;
        logic [47:0] v;
        case (ph)
            PH_HEADER: begin
                if (cnt < 4) begin
                    if (b != MAGIC_WORD[8*(3-cnt) +: 8]) begin
                        fault(ST_BAD_MAGIC);
                        return;
                    end
                end else if (cnt < 8) begin
                    if (b != 0) begin
                        fault(ST_TOO_LARGE);
                        return;
                    end
                end else if (cnt < 12) begin
                    exp_len = {exp_len[23:0], b};
                end
                if (cnt == 15) begin
                    ph = PH_TOKEN;
                    cnt = 0;
                end else begin
                    cnt = cnt + 1;
                end
            end
            PH_TOKEN: begin
                if (cnt == 0) begin
                    len = tok_size(b);
                    if (len == 0) fault(ST_BAD_TOKEN);
                    else if (len == 1) close_token(48'(b), 1);
                    else begin
                        tok = 40'(b);
                        cnt = 1;
                    end
                    return;
                end
                len = tok_size(tok[8*(cnt-1) +: 8]);
                v = {tok, b};
                if (cnt + 1 >= len) begin
                    cnt = 0;
                    tok = 0;
                    close_token(v, len);
                end else begin
                    tok = v[39:0];
                    cnt = cnt + 1;
                end
            end
            PH_LITERAL: begin
                put_out(b);
                lit_left = lit_left - 1;
                if (lit_left == 0) ph = PH_TOKEN;
            end
            PH_COPY: fault(ST_BUSY);
            PH_TRAILER: begin
                trl = {trl[23:0], b};
                cnt = cnt + 1;
                if (cnt == 4) begin
                    cnt = 0;
                    if (n_out != exp_len) fault(ST_LEN_MISMT);
                    else if ({sum_b, sum_a} != trl) fault(ST_SUM_MISMT);
                    else ph = PH_DONE;
                end
            end
            default: ;
        endcase
    endfunction

    function void decode_word(logic kind, logic [7:0] b);
        res_t r;
        cur_valid = 1'b0;
        cur_byte = 8'h00;
        if (kind == REQ_TICK) begin
            if (ph == PH_COPY) begin
                put_out(hist[16'(n_out - (32'(cp_dist) + 1))]);
                cp_left = cp_left - 1;
                if (cp_left == 0) ph = PH_TOKEN;
            end
        end else begin
            take_byte(b);
        end
        r.out_valid = cur_valid;
        r.out_byte = cur_byte;
        r.copy_pending = (ph == PH_COPY);
        r.done_res = (ph == PH_DONE);
        r.status = err;
        expected_res = {expected_res, r};
    endfunction

    // ---------------- stream builder ----------------
    function void push_word(logic kind, logic [7:0] b);
        word_t w;
        w.kind = kind;
        w.b = b;
        pending = {pending, w};
    endfunction

    function void push_bytes(logic [47:0] v, int n);
        for (int i = n - 1; i >= 0; i--) push_word(REQ_BYTE, v[8*i +: 8]);
    endfunction

    function void push_lit(logic [7:0] b);
        push_word(REQ_BYTE, b);
        gen_out = {gen_out, b};
    endfunction

    function void add_literal(tok_kind_t k, int run);
        case (k)
            TK_LIT_SHORT: push_bytes(48'(8'h20 + run - 1), 1);
            TK_LIT_MID:   push_bytes(48'(16'h0800 + run - 1), 2);
            default:      push_bytes({24'h0, 8'h07, 16'(run - 1)}, 3);
        endcase
        for (int i = 0; i < run; i++) push_lit(8'($urandom_range(0, 255)));
    endfunction

    // busy: a compressed byte is slipped in while the copy is still running
    function void add_match(tok_kind_t k, int offs, int run, bit busy);
        int sz;
        case (k)
            TK_MATCH_S:  push_bytes({32'h0, 8'(8'h80 + run - 1), 8'(offs - 1)}, 2);
            TK_MATCH_M:  push_bytes({24'h0, 16'(16'h4000 + offs - 1), 8'(run - 1)}, 3);
            TK_MATCH_L:  push_bytes({16'h0, 24'(24'h180000 + offs - 1), 8'(run - 1)}, 4);
            TK_MATCH_LL: push_bytes({8'h0, 24'(24'h100000 + offs - 1), 16'(run - 1)}, 5);
            TK_MATCH_X:  push_bytes({8'h0, 8'h06, 24'(offs - 1), 8'(run - 1)}, 5);
            default:     push_bytes({8'h04, 24'(offs - 1), 16'(run - 1)}, 6);
        endcase
        if (busy) push_word(REQ_BYTE, 8'($urandom_range(0, 255)));
        for (int i = 0; i < run; i++) begin
            push_word(REQ_TICK, 8'($urandom_range(0, 255)));
            sz = gen_out.size();
            if (offs <= sz) gen_out = {gen_out, gen_out[sz - offs]};
        end
    endfunction

    function automatic int dist_cap(tok_kind_t k);
        case (k)
            TK_MATCH_S: return 256;
            TK_MATCH_M: return 16384;
            TK_MATCH_L, TK_MATCH_LL: return 32'h80000;
            default: return 32'h1000000;
        endcase
    endfunction

    function automatic int run_cap(tok_kind_t k);
        case (k)
            TK_LIT_SHORT: return 32;
            TK_MATCH_S: return 128;
            TK_MATCH_M, TK_MATCH_L, TK_MATCH_X: return 256;
            TK_LIT_MID: return 2048;
            default: return 65536;
        endcase
    endfunction

    function automatic logic [31:0] adler_of();
        logic [31:0] a;
        logic [31:0] b;
        a = 1;
        b = 0;
        foreach (gen_out[i]) begin
            a = (a + gen_out[i]) % 65521;
            b = (b + a) % 65521;
        end
        return {b[15:0], a[15:0]};
    endfunction

    function void build_stream();
        int          total;
        int          rem;
        int          run;
        int          offs;
        int          cap;
        tok_kind_t   k;
        end_kind_t   ending;
        logic [31:0] sum;
        logic [7:0]  hdr[16];
        total = $urandom_range(770, 850);
        ending = end_kind_t'($urandom_range(0, 12) < 4 ? END_GOOD : $urandom_range(1, 9));
        hdr = '{8'h57, 8'hBC, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                total[31:24], total[23:16], total[15:8], total[7:0],
                8'h5A, 8'hA5, 8'hFF, 8'h00};
        if (ending == END_MAGIC) begin
            rem = $urandom_range(0, 3);
            hdr[rem] = hdr[rem] ^ 8'(1 << $urandom_range(0, 7));
        end
        if (ending == END_UPPER) hdr[$urandom_range(4, 7)] = 8'(1 << $urandom_range(0, 7));
        foreach (hdr[i]) push_word(REQ_BYTE, hdr[i]);

        // directed: idle tick, byte extremes, overlapping copy, every token form
        push_word(REQ_TICK, 8'hFF);
        push_bytes(48'h21, 1);
        push_lit(8'h00);
        push_lit(8'hFF);
        add_literal(TK_LIT_SHORT, 32);
        add_match(TK_MATCH_S, 1, 12, 0);
        add_match(TK_MATCH_S, 40, 5, 0);
        add_match(TK_MATCH_M, 45, 3, 0);
        add_match(TK_MATCH_L, 7, 2, 0);
        add_match(TK_MATCH_LL, 2, 4, 0);
        add_match(TK_MATCH_X, 50, 3, 0);
        add_match(TK_MATCH_XL, 3, 2, 0);
        add_literal(TK_LIT_MID, 3);
        add_literal(TK_LIT_LONG, 2);
        push_word(REQ_TICK, 8'h00);

        while (gen_out.size() < total - 1) begin
            rem = total - 1 - gen_out.size();
            k = tok_kind_t'($urandom_range(0, 8));
            cap = ($urandom_range(0, 9) == 0) ? 64 : 16;
            if (run_cap(k) < cap) cap = run_cap(k);
            if (rem < cap) cap = rem;
            run = $urandom_range(1, cap);
            if (k <= TK_LIT_LONG) begin
                add_literal(k, run);
            end else begin
                cap = gen_out.size();
                if (dist_cap(k) < cap) cap = dist_cap(k);
                if ($urandom_range(0, 1) == 0 && cap > 8) cap = 8;
                offs = $urandom_range(1, cap);
                add_match(k, offs, run, 0);
            end
            if ($urandom_range(0, 19) == 0) push_word(REQ_TICK, 8'($urandom_range(0, 255)));
        end

        // one byte of output is held back so every ending can be shaped
        case (ending)
            END_LEN: ;
            END_BAD_TOKEN: push_word(REQ_BYTE, 8'($urandom_range(0, 3)));
            END_BAD_FA: push_bytes({32'h0, 8'h05, 8'($urandom_range(0, 249))}, 2);
            END_OVERFLOW: add_literal(TK_LIT_SHORT, 2);
            END_BAD_DIST: add_match(TK_MATCH_XL, gen_out.size() + 1, 1, 0);
            END_BUSY: add_match(TK_MATCH_S, 1, 1, 1);
            default: add_literal(TK_LIT_SHORT, 1);
        endcase
        sum = adler_of();
        if (ending == END_SUM) sum = sum ^ (32'h1 << $urandom_range(0, 31));
        push_bytes({16'h0, 8'h05, TRAILER_B1}, 2);
        push_bytes(48'(sum), 4);
        // trailing words are ignored by the block
        for (int i = 0; i < 30; i++)
            push_word(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
    endfunction

    // ---------------- driver ----------------
    int in_gap = 0;

    function automatic int pick_gap();
        int r;
        if ($urandom_range(0, 49) == 0) quiet = ~quiet;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 94) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    always @(posedge aclk) begin
        word_t w;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) decode_word(s_tuser, s_tdata);
            if (!s_tvalid || s_tready) begin
                if (in_gap > 0) begin
                    in_gap--;
                    s_tvalid <= 1'b0;
                end else if (pending.size() > 0) begin
                    w = pending.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= w.b;
                    s_tuser <= w.kind;
                    in_gap = pick_gap();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ---------------- monitor ----------------
    int  out_gap = 0;
    int  hold_left = 0;
    bit  held = 0;

    task automatic report(string field, int got, int want);
        $display("%0t: word %0d %s mismatch: got %0h expected %0h",
                 $realtime, words_out, field, got, want);
        errors++;
    endtask

    always @(posedge aclk) begin
        res_t got;
        res_t want;
        bit   ready;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got = res_t'(m_tdata[14:0]);
                if (expected_res.size() == 0) begin
                    report("unexpected word", int'(m_tdata), 0);
                end else begin
                    want = expected_res.pop_front();
                    if (got.out_valid != want.out_valid)
                        report("out_valid", got.out_valid, want.out_valid);
                    if (got.out_byte != want.out_byte)
                        report("out_byte", got.out_byte, want.out_byte);
                    if (got.copy_pending != want.copy_pending)
                        report("copy_pending", got.copy_pending, want.copy_pending);
                    if (got.done_res != want.done_res)
                        report("done_res", got.done_res, want.done_res);
                    if (got.status != want.status)
                        report("status", got.status, want.status);
                end
                words_out++;
            end
            if (hold_left > 0) begin
                ready = 0;
            end else if (out_gap > 0) begin
                out_gap--;
                ready = 0;
            end else begin
                ready = 1;
                out_gap = pick_gap();
            end
            m_tready <= ready;
        end
    end

    // one long hold-off so the block backs up into s_tready
    always @(posedge aclk) begin
        if (aresetn) begin
            if (!held && words_out >= 300) begin
                held = 1;
                hold_left = 250;
            end else if (hold_left > 0) begin
                hold_left--;
            end
        end
    end

    // ---------------- watchdog ----------------
    int stuck = 0;

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stuck = 0;
            else stuck++;
            if (stuck >= STALL_LIMIT) begin
                $display("lz_stream_decompressor_tb: FAIL");
                $finish;
            end
        end
    end

    initial begin
        build_stream();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        while (pending.size() > 0 || s_tvalid || expected_res.size() > 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (errors == 0) begin
            $display("lz_stream_decompressor_tb: PASS");
        end else begin
            $display("lz_stream_decompressor_tb: FAIL");
        end
        $finish;
    end

endmodule
